// ===== sv/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, widths and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // field and datapath widths
  localparam int TRIG_W   = 8;
  localparam int TICK_W   = 12;
  localparam int COUNT_W  = 16;
  localparam int SCALE_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = COUNT_W + SCALE_W;
  localparam int DIST_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // moving average window
  localparam int WINDOW   = 5;
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W    = DIST_W + $clog2(WINDOW);

  // divide by WINDOW as multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam logic [RECIP_SHIFT:0] RECIP =
    (RECIP_SHIFT + 1)'(((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW);
  localparam int DIV_W    = SUM_W + RECIP_SHIFT + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // words in flight between accept and delivery
  localparam int PIPE_STAGES = 4;

  // register reset values
  localparam logic [TRIG_W-1:0]  TRIG_HIGH_RST = 8'd10;
  localparam logic [TICK_W-1:0]  TPC_RST       = 12'd64;
  localparam logic [COUNT_W-1:0] TIMEOUT_RST   = 16'd65000;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd838861;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_HIGH    = 2'd0,
    CFG_TICKS_PER_COUNT = 2'd1,
    CFG_TIMEOUT         = 2'd2,
    CFG_SCALE           = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_high_ticks;
    logic [TICK_W-1:0]  ticks_per_count;
    logic [COUNT_W-1:0] timeout_count;
    logic [SCALE_W-1:0] scale_mult;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_word_t;

  typedef struct packed {
    logic              trigger_out;
    logic              busy_res;
    logic              done_res;
    logic              no_echo;
    logic [DIST_W-1:0] last_distance;
    logic [DIST_W-1:0] avg_distance;
  } out_word_t;

  // per-tick status flags carried down the pipeline
  typedef struct packed {
    logic trigger_out;
    logic busy_res;
    logic done_res;
    logic no_echo;
  } status_t;

  typedef struct packed {
    status_t            st;
    logic               sample_v;
    logic [COUNT_W-1:0] sample_cnt;
  } ctl_word_t;

  typedef struct packed {
    status_t           st;
    logic              sample_v;
    logic [PROD_W-1:0] prod;
  } scl_word_t;

endpackage

// ===== sv/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger pulse, echo wait, echo width count.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  uer_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  uer_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output uer_pkg::ctl_word_t out_word
);
  import uer_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [TICK_W-1:0]  tick_cnt, tick_cnt_next;
  logic [COUNT_W-1:0] echo_cnt, echo_cnt_next;
  ctl_word_t          word_next;

  logic [TICK_W-1:0]  tpc;
  logic [TRIG_W-1:0]  high;
  logic [TICK_W-1:0]  tick_inc;
  logic               wrap;
  logic               expire;
  logic [TICK_W-1:0]  adv_tick;
  logic [COUNT_W-1:0] adv_echo;
  logic               accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // prescaler step and timeout check
  always_comb begin
    tpc      = (cfg.ticks_per_count == '0) ? TICK_W'(1) : cfg.ticks_per_count;
    high     = (cfg.trigger_high_ticks == '0) ? TRIG_W'(1) : cfg.trigger_high_ticks;
    tick_inc = tick_cnt + TICK_W'(1);
    wrap     = tick_inc >= tpc;
    expire   = wrap && (echo_cnt >= cfg.timeout_count);
    adv_tick = wrap ? '0 : tick_inc;
    adv_echo = (wrap && !expire) ? echo_cnt + COUNT_W'(1) : echo_cnt;
  end

  // phase sequencing
  always_comb begin
    phase_next    = phase;
    tick_cnt_next = tick_cnt;
    echo_cnt_next = echo_cnt;
    word_next     = '0;
    unique case (phase)
      PH_IDLE: begin
        if (in_word.start_req) begin
          word_next.st.busy_res = 1'b1;
          phase_next    = PH_TRIG;
          tick_cnt_next = '0;
        end
      end
      PH_TRIG: begin
        word_next.st.trigger_out = 1'b1;
        word_next.st.busy_res    = 1'b1;
        if (tick_inc >= TICK_W'(high)) begin
          phase_next    = PH_WAIT;
          tick_cnt_next = '0;
          echo_cnt_next = '0;
        end else begin
          tick_cnt_next = tick_inc;
        end
      end
      PH_WAIT: begin
        word_next.st.busy_res = 1'b1;
        if (in_word.echo) begin
          phase_next    = PH_MEAS;
          tick_cnt_next = '0;
          echo_cnt_next = '0;
        end else if (expire) begin
          word_next.st.busy_res = 1'b0;
          word_next.st.done_res = 1'b1;
          word_next.st.no_echo  = 1'b1;
          phase_next    = PH_IDLE;
          tick_cnt_next = '0;
        end else begin
          tick_cnt_next = adv_tick;
          echo_cnt_next = adv_echo;
        end
      end
      PH_MEAS: begin
        word_next.st.busy_res = 1'b1;
        if (in_word.echo) begin
          if (expire) begin
            // echo too long: sample of zero
            word_next.st.busy_res = 1'b0;
            word_next.st.done_res = 1'b1;
            word_next.sample_v    = 1'b1;
            word_next.sample_cnt  = '0;
            echo_cnt_next = '0;
            phase_next    = PH_IDLE;
            tick_cnt_next = '0;
          end else begin
            tick_cnt_next = adv_tick;
            echo_cnt_next = adv_echo;
          end
        end else begin
          word_next.st.busy_res = 1'b0;
          word_next.st.done_res = 1'b1;
          word_next.sample_v    = 1'b1;
          word_next.sample_cnt  = echo_cnt;
          phase_next    = PH_IDLE;
          tick_cnt_next = '0;
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        tick_cnt_next = '0;
      end
    endcase
  end

  // control state and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      tick_cnt  <= '0;
      echo_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        tick_cnt <= tick_cnt_next;
        echo_cnt <= echo_cnt_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== sv/uer_scale.sv =====
// ----------------------------------------------------------------------------
// uer_scale
// Multiplies the echo count by the distance scale factor.
// ----------------------------------------------------------------------------
module uer_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [uer_pkg::SCALE_W-1:0] scale_mult,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  uer_pkg::ctl_word_t       in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output uer_pkg::scl_word_t       out_word
);
  import uer_pkg::*;

  scl_word_t word_next;

  assign in_ready = !out_valid || out_ready;

  // count times scale, full product
  always_comb begin
    word_next.st       = in_word.st;
    word_next.sample_v = in_word.sample_v;
    word_next.prod     = PROD_W'(in_word.sample_cnt) * PROD_W'(scale_mult);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== sv/uer_avg.sv =====
// ----------------------------------------------------------------------------
// uer_avg
// Distance saturation, sample window with running sum, and the average.
// ----------------------------------------------------------------------------
module uer_avg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uer_pkg::scl_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output uer_pkg::out_word_t out_word
);
  import uer_pkg::*;

  typedef struct packed {
    status_t           st;
    logic [DIST_W-1:0] latest;
    logic [SUM_W-1:0]  sum;
  } sum_word_t;

  // window state
  logic [DIST_W-1:0] win [WINDOW];
  logic [POS_W-1:0]  wr_pos, wr_pos_next;
  logic [SUM_W-1:0]  run_sum, run_sum_next;
  logic [DIST_W-1:0] latest, latest_next;

  // sum stage
  logic              sum_valid;
  logic              sum_ready;
  sum_word_t         sum_word, sum_word_next;
  logic              take;
  logic [PROD_W-FRAC_W-1:0] dist_full;
  logic [DIST_W-1:0] dist_sat;

  // divide stage
  logic [DIV_W-1:0]  avg_prod;
  out_word_t         out_next;

  assign in_ready  = !sum_valid || sum_ready;
  assign sum_ready = !out_valid || out_ready;
  assign take      = in_valid && in_ready && in_word.sample_v;

  // saturate and update the running sum
  always_comb begin
    dist_full    = in_word.prod[PROD_W-1:FRAC_W];
    dist_sat     = (dist_full > (PROD_W-FRAC_W)'(DIST_MAX)) ? DIST_MAX
                                                          : dist_full[DIST_W-1:0];
    latest_next  = in_word.sample_v ? dist_sat : latest;
    run_sum_next = run_sum - SUM_W'(win[wr_pos]) + SUM_W'(dist_sat);
    wr_pos_next  = (wr_pos == POS_W'(WINDOW - 1)) ? '0 : wr_pos + POS_W'(1);
    sum_word_next.st     = in_word.st;
    sum_word_next.latest = latest_next;
    sum_word_next.sum    = in_word.sample_v ? run_sum_next : run_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        win[i] <= '0;
      end
      wr_pos    <= '0;
      run_sum   <= '0;
      latest    <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (take) begin
        win[wr_pos] <= dist_sat;
        wr_pos      <= wr_pos_next;
        run_sum     <= run_sum_next;
        latest      <= dist_sat;
      end
      if (in_ready) begin
        sum_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum_word <= sum_word_next;
    end
  end

  // divide by the window length via reciprocal multiply
  always_comb begin
    avg_prod               = DIV_W'(sum_word.sum) * DIV_W'(RECIP);
    out_next.trigger_out   = sum_word.st.trigger_out;
    out_next.busy_res      = sum_word.st.busy_res;
    out_next.done_res      = sum_word.st.done_res;
    out_next.no_echo       = sum_word.st.no_echo;
    out_next.last_distance = sum_word.latest;
    out_next.avg_distance  = avg_prod[RECIP_SHIFT +: DIST_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      out_word <= out_next;
    end
  end

endmodule

// ===== sv/ultrasonic_echo_ranger_avg.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_avg
// Ultrasonic ranging sequencer with a moving average of measured distances.
// ----------------------------------------------------------------------------
// Each input word is one base tick and gives exactly one output word. A new
// tick word is taken every clock cycle while in_stall is low. Its output word
// then passes the four register stages: sequencer (loaded at the accepting
// edge), scale multiply, window and running-sum update, and divide-by-window
// multiply. Output stalls fill the stages first, so input stall rises only
// when all four hold a word and the output is stalled. The sample window lives
// in flip-flops cleared by reset, so the block is ready right after reset. The
// user must write registers through the cfg port only while no measurement is
// under way and no word is in flight; the block does not enforce this.
module ultrasonic_echo_ranger_avg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  uer_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output uer_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  cfg_t      cfg;
  logic      ctl_in_ready;
  logic      ctl_valid, ctl_ready;
  ctl_word_t ctl_word;
  logic      scl_valid, scl_ready;
  scl_word_t scl_word;

  // register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_high_ticks <= TRIG_HIGH_RST;
      cfg.ticks_per_count    <= TPC_RST;
      cfg.timeout_count      <= TIMEOUT_RST;
      cfg.scale_mult         <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIGGER_HIGH:    cfg.trigger_high_ticks <= cfg_data[TRIG_W-1:0];
        CFG_TICKS_PER_COUNT: cfg.ticks_per_count    <= cfg_data[TICK_W-1:0];
        CFG_TIMEOUT:         cfg.timeout_count      <= cfg_data[COUNT_W-1:0];
        CFG_SCALE:           cfg.scale_mult         <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !ctl_in_ready;

  // sequencer stage
  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (ctl_in_ready),
    .in_word   (in_data),
    .out_valid (ctl_valid),
    .out_ready (ctl_ready),
    .out_word  (ctl_word)
  );

  // scale multiply stage
  uer_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .scale_mult (cfg.scale_mult),
    .in_valid   (ctl_valid),
    .in_ready   (ctl_ready),
    .in_word    (ctl_word),
    .out_valid  (scl_valid),
    .out_ready  (scl_ready),
    .out_word   (scl_word)
  );

  // averaging and output stages
  uer_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_word   (scl_word),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_word  (out_data)
  );

endmodule

// ===== sv/uer_checker.sv =====
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input uer_pkg::out_word_t             out_data
);
  import uer_pkg::*;

  localparam int OCC_W = $clog2(PIPE_STAGES + 1);

  logic              in_acc, out_acc;
  logic [OCC_W-1:0]  occ;
  logic [DIST_W-1:0] prev_last, prev_avg;
  logic              new_sample;

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign new_sample = out_data.done_res && !out_data.no_echo;

  // words in flight and last delivered distances
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      prev_last <= '0;
      prev_avg  <= '0;
    end else begin
      occ <= occ + OCC_W'(in_acc) - OCC_W'(out_acc);
      if (out_acc) begin
        prev_last <= out_data.last_distance;
        prev_avg  <= out_data.avg_distance;
      end
    end
  end

  // never more words in flight than stages
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(PIPE_STAGES))
    else $error("more words in flight than pipeline stages");

  // no output word without an accepted input word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != '0)
    else $error("output word without matching input word");

  // distances change only on a finished measurement with a sample
  a_dist_hold: assert property (@(posedge clk) disable iff (rst)
    out_acc && !new_sample |->
      out_data.last_distance == prev_last && out_data.avg_distance == prev_avg)
    else $error("distance changed without a new sample");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind ultrasonic_echo_ranger_avg uer_checker u_uer_checker (.*);

// ===== tb/tb_ultrasonic_echo_ranger_avg.sv =====
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_avg
// Self-checking bench for the ultrasonic echo ranger with moving average.
// ----------------------------------------------------------------------------
// Every accepted tick word runs through a bit-exact behavioral copy of the
// ranger (trigger sequencing, echo wait and width count with prescaler and
// timeout, scaled distance, five-entry running average). The report words it
// computes are queued and compared field by field with the block's output.
// Directed tests cover reset settings, the echo corner cases, zero and extreme
// register values and output back-pressure; random traffic follows.
module tb_ultrasonic_echo_ranger_avg;
  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned TICKS_PER_PHASE = 100;

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} ranger_phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // behavioral copy of the ranger state and registers
  cfg_t                rg_cfg;
  ranger_phase_t       rg_phase;
  logic [TICK_W-1:0]   rg_ticks;
  logic [COUNT_W-1:0]  rg_count;
  logic [DIST_W-1:0]   rg_latest;
  logic [DIST_W-1:0]   rg_window [WINDOW];
  logic [SUM_W-1:0]    rg_sum;
  logic [POS_W-1:0]    rg_wpos;

  out_word_t   tick_reports [$];
  out_word_t   want_word;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned live_ticks = 0;
  int unsigned rangings = 0;
  int unsigned misses = 0;
  int unsigned saturations = 0;
  int unsigned settings_used = 0;

  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned stall_left = 0;

  ultrasonic_echo_ranger_avg dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // prescaler step; returns 1 when the count has reached the timeout at a wrap
  function automatic bit prescale_step();
    logic [TICK_W-1:0] per;
    per = (rg_cfg.ticks_per_count != 0) ? rg_cfg.ticks_per_count : TICK_W'(1);
    rg_ticks = rg_ticks + TICK_W'(1);
    if (rg_ticks >= per) begin
      rg_ticks = '0;
      if (rg_count >= rg_cfg.timeout_count) return 1'b1;
      rg_count = rg_count + COUNT_W'(1);
    end
    return 1'b0;
  endfunction

  // scale a count into a distance and push it into the averaging window
  function automatic void store_distance(logic [COUNT_W-1:0] cnt);
    logic [PROD_W-1:0] prod;
    prod = (PROD_W'(cnt) * PROD_W'(rg_cfg.scale_mult)) >> FRAC_W;
    if (prod > PROD_W'(DIST_MAX)) begin
      prod = PROD_W'(DIST_MAX);
      saturations++;
    end
    rg_latest = prod[DIST_W-1:0];
    rg_sum = rg_sum - SUM_W'(rg_window[rg_wpos]) + SUM_W'(rg_latest);
    rg_window[rg_wpos] = rg_latest;
    rg_wpos = (rg_wpos == POS_W'(WINDOW - 1)) ? '0 : rg_wpos + POS_W'(1);
  endfunction

  // one base tick of the ranger: advances the state, returns its report word
  function automatic out_word_t ranger_tick(in_word_t word);
    out_word_t         rep;
    logic [TRIG_W-1:0] high;
    high = (rg_cfg.trigger_high_ticks != 0) ? rg_cfg.trigger_high_ticks : TRIG_W'(1);
    rep = '0;
    case (rg_phase)
      PH_IDLE: begin
        if (word.start_req) begin
          rep.busy_res = 1'b1;
          rg_phase = PH_TRIG;
          rg_ticks = '0;
        end
      end
      PH_TRIG: begin
        rep.trigger_out = 1'b1;
        rep.busy_res = 1'b1;
        rg_ticks = rg_ticks + TICK_W'(1);
        if (rg_ticks >= TICK_W'(high)) begin
          rg_phase = PH_WAIT;
          rg_ticks = '0;
          rg_count = '0;
        end
      end
      PH_WAIT: begin
        rep.busy_res = 1'b1;
        if (word.echo) begin
          rg_phase = PH_MEAS;
          rg_ticks = '0;
          rg_count = '0;
        end else if (prescale_step()) begin
          rep.busy_res = 1'b0;
          rep.done_res = 1'b1;
          rep.no_echo = 1'b1;
          rg_phase = PH_IDLE;
          rg_ticks = '0;
          misses++;
          rangings++;
        end
      end
      default: begin
        rep.busy_res = 1'b1;
        if (!word.echo || prescale_step()) begin
          // echo fell: take the count; echo too long: take zero
          if (word.echo) begin
            rg_count = '0;
            store_distance('0);
          end else begin
            store_distance(rg_count);
          end
          rep.busy_res = 1'b0;
          rep.done_res = 1'b1;
          rg_phase = PH_IDLE;
          rg_ticks = '0;
          rangings++;
        end
      end
    endcase
    rep.last_distance = rg_latest;
    rep.avg_distance = DIST_W'(rg_sum / SUM_W'(WINDOW));
    return rep;
  endfunction

  // offer one tick word and hold it until accepted
  task automatic send_tick(input logic start, input logic echo_lvl);
    in_word_t word;
    word.start_req = start;
    word.echo = echo_lvl;
    in_valid <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (rg_phase != PH_IDLE || start) live_ticks++;
    items_sent++;
    tick_reports.push_back(ranger_tick(word));
  endtask

  // random idle time on the input side
  task automatic sender_pause();
    int unsigned n;
    n = gaps_on ? pick_gap() : 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering words until every report has come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
  endtask

  // close any measurement quickly, then drain
  task automatic settle_idle();
    while (rg_phase != PH_IDLE)
      send_tick(1'($urandom_range(0, 1)), rg_phase == PH_WAIT);
    drain_reports();
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_TRIGGER_HIGH:    rg_cfg.trigger_high_ticks = data[TRIG_W-1:0];
      CFG_TICKS_PER_COUNT: rg_cfg.ticks_per_count = data[TICK_W-1:0];
      CFG_TIMEOUT:         rg_cfg.timeout_count = data[COUNT_W-1:0];
      default:             rg_cfg.scale_mult = data[SCALE_W-1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new register setting, written only with the block idle and empty
  task automatic program_ranger(input logic [CFG_DATA_W-1:0] trig,
                                input logic [CFG_DATA_W-1:0] tpc,
                                input logic [CFG_DATA_W-1:0] tmo,
                                input logic [CFG_DATA_W-1:0] scale);
    settle_idle();
    write_reg(CFG_TRIGGER_HIGH, trig);
    write_reg(CFG_TICKS_PER_COUNT, tpc);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_SCALE, scale);
    settings_used++;
  endtask

  // one measurement: echo rises after wait_ticks waiting ticks and stays
  // high for high_ticks measuring ticks; start bits outside idle are noise
  task automatic run_measurement(input int unsigned wait_ticks,
                                 input int unsigned high_ticks);
    int unsigned waited;
    int unsigned held;
    bit          started;
    waited = 0;
    held = 0;
    started = (rg_phase != PH_IDLE);
    while (!started || rg_phase != PH_IDLE) begin
      sender_pause();
      case (rg_phase)
        PH_IDLE: begin
          send_tick(1'b1, 1'($urandom_range(0, 1)));
          started = 1'b1;
        end
        PH_TRIG: send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        PH_WAIT: begin
          send_tick(1'($urandom_range(0, 1)), waited >= wait_ticks);
          waited++;
        end
        default: begin
          send_tick(1'($urandom_range(0, 1)), held < high_ticks);
          held++;
        end
      endcase
    end
  endtask

  // reset register values: default trigger, prescaler and scale
  task automatic test_default_settings();
    run_measurement(5, 130);
    run_measurement(0, 70);
  endtask

  // echo already high on the first waiting tick
  task automatic test_echo_at_first_wait_tick();
    program_ranger(1, 1, 10, 24'h010000);
    run_measurement(0, 4);
    run_measurement(0, 1);
  endtask

  // no echo, echo too long, echo falling on the first measuring tick
  task automatic test_echo_timeouts();
    program_ranger(3, 2, 6, 24'h030000);
    run_measurement(100, 0);
    run_measurement(2, 100);
    run_measurement(1, 0);
    run_measurement(4, 9);
  endtask

  // zero trigger length, prescaler and timeout
  task automatic test_zero_registers();
    program_ranger(0, 0, 0, 24'h010000);
    run_measurement(50, 0);
    run_measurement(0, 10);
    run_measurement(0, 0);
  endtask

  // largest trigger, prescaler, timeout and scale, zero scale
  task automatic test_register_extremes();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    program_ranger(255, 4095, 1, 24'hFFFFFF);
    run_measurement(4, 3);
    program_ranger(1, 1, 65535, 24'hFFFFFF);
    run_measurement(3, 40);
    program_ranger(1, 1, 65535, 0);
    run_measurement(2, 30);
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // long output hold so the block fills and stalls, then a mid-run pause
  task automatic test_output_hold();
    program_ranger(20, 2, 15, 24'h030000);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    hold_request = 1'b1;
    run_measurement(6, 12);
    send_tick(1'b1, 1'b0);
    drain_reports();
    run_measurement(3, 5);
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // random settings and traffic, mostly whole measurements plus noise
  task automatic test_random_traffic();
    int unsigned trig;
    int unsigned scale;
    int unsigned span;
    int unsigned first;
    int unsigned r;
    int unsigned wait_ticks;
    int unsigned high_ticks;
    logic [CFG_DATA_W-1:0] junk;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      trig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      r = $urandom_range(0, 9);
      scale = (r == 0) ? 0 : (r == 1) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
      // junk above the trigger, prescaler and timeout fields must be ignored by the block
      junk = CFG_DATA_W'($urandom);
      program_ranger((junk << TRIG_W) | CFG_DATA_W'(trig),
                     (junk << TICK_W) | CFG_DATA_W'($urandom_range(0, 5)),
                     (junk << COUNT_W) | CFG_DATA_W'($urandom_range(0, 40)),
                     CFG_DATA_W'(scale));
      gaps_on = (p != 3);
      stall_on = (p != 3);
      span = (rg_cfg.timeout_count + 1) *
             ((rg_cfg.ticks_per_count != 0) ? rg_cfg.ticks_per_count : 1);
      first = live_ticks;
      while (live_ticks - first < TICKS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            sender_pause();
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          wait_ticks = ($urandom_range(0, 9) < 8) ? $urandom_range(0, span) : span + 10;
          r = $urandom_range(0, 9);
          high_ticks = (r < 7) ? $urandom_range(1, span) : (r < 9) ? span + 10 : 0;
          run_measurement(wait_ticks, high_ticks);
        end
      end
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // output stall: requested long hold, else random short and long bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each accepted report word with the oldest outstanding one
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (tick_reports.size() == 0) begin
        $display("%0t: report word %h with none outstanding", $time, out_data);
        errors++;
      end else begin
        want_word = tick_reports.pop_front();
        check_field("trigger_out", DIST_W'(want_word.trigger_out),
                    DIST_W'(out_data.trigger_out));
        check_field("busy_res", DIST_W'(want_word.busy_res), DIST_W'(out_data.busy_res));
        check_field("done_res", DIST_W'(want_word.done_res), DIST_W'(out_data.done_res));
        check_field("no_echo", DIST_W'(want_word.no_echo), DIST_W'(out_data.no_echo));
        check_field("last_distance", want_word.last_distance, out_data.last_distance);
        check_field("avg_distance", want_word.avg_distance, out_data.avg_distance);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d reports outstanding",
               cycles, tick_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rg_cfg = '{TRIG_HIGH_RST, TPC_RST, TIMEOUT_RST, SCALE_RST};
    rg_phase = PH_IDLE;
    rg_ticks = '0;
    rg_count = '0;
    rg_latest = '0;
    foreach (rg_window[i]) rg_window[i] = '0;
    rg_sum = '0;
    rg_wpos = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_echo_at_first_wait_tick();
    test_echo_timeouts();
    test_zero_registers();
    test_register_extremes();
    test_output_hold();
    test_random_traffic();

    settle_idle();
    repeat (PIPE_STAGES + 4) @(posedge clk);
    if (tick_reports.size() != 0) begin
      $display("%0t: %0d report words never arrived", $time, tick_reports.size());
      errors++;
    end
    $display("run covered %0d tick words over %0d register settings", items_sent,
             settings_used + 1);
    $display("%0d measurements finished, %0d without echo, %0d clipped distances",
             rangings, misses, saturations);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
